FILE: design/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator package
// Beat types, opcodes and status codes shared by the calculator modules.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int DATA_WIDTH = 32;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_END  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	typedef struct packed {
		logic [2:0]                   opcode;
		logic signed [DATA_WIDTH-1:0] operand_value;
	} token_beat_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic signed [DATA_WIDTH-1:0] result_value;
		logic                         expression_done;
		logic [4:0]                   stack_depth;
	} result_beat_t;

endpackage

FILE: design/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// Add, subtract or multiply two operands, result wrapped to the data width.
// ----------------------------------------------------------------------------
module rpn_alu (
	input  logic [2:0]                     opcode,
	input  logic [rpn_pkg::DATA_WIDTH-1:0] left,
	input  logic [rpn_pkg::DATA_WIDTH-1:0] right,
	output logic [rpn_pkg::DATA_WIDTH-1:0] y
);

	logic [2*rpn_pkg::DATA_WIDTH-1:0] prod;

	assign prod = left * right;

	always_comb begin
		unique case (opcode)
			rpn_pkg::OP_ADD: y = left + right;
			rpn_pkg::OP_SUB: y = left - right;
			rpn_pkg::OP_MUL: y = prod[rpn_pkg::DATA_WIDTH-1:0];
			default:         y = '0;
		endcase
	end

endmodule

FILE: design/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator
// Each accepted token registers a result beat, valid in the cycle after; one
// token per cycle while results are not stalled. The top two stack entries
// live in registers, the third is prefetched from RAM each cycle: pops never wait.
// Reset clears the stack pointer, the held error and the result valid.
// The stack RAM is not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  token_valid,
	output logic                  token_stall,
	input  rpn_pkg::token_beat_t  token,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rpn_pkg::result_beat_t result
);

	localparam int SpW   = $clog2(STACK_DEPTH + 1);
	localparam int AddrW = $clog2(STACK_DEPTH);
	localparam int DW    = rpn_pkg::DATA_WIDTH;

	logic [SpW-1:0]        sp_q, sp_d, sp_m2, rd_ptr;
	logic [1:0]            held_q, held_d;
	logic [DW-1:0]         top_q, top_d, nxt_q, nxt_d;
	logic                  res_valid_q;
	rpn_pkg::result_beat_t res_q, beat_d;
	logic                  accept, full, has_two;
	logic                  we;
	logic [AddrW-1:0]      waddr, raddr;
	logic [DW-1:0]         wdata, ram_rd, alu_y;
	logic [SpW+4:0]        depth_wide;

	assign accept      = token_valid & ~token_stall;
	assign token_stall = res_valid_q & result_stall;
	assign full        = (sp_q == SpW'(STACK_DEPTH));
	assign has_two     = (sp_q >= SpW'(2));
	assign sp_m2       = sp_q - SpW'(2);

	rpn_alu u_alu (
		.opcode (token.opcode),
		.left   (nxt_q),
		.right  (top_q),
		.y      (alu_y)
	);

	always_comb begin
		sp_d   = sp_q;
		held_d = held_q;
		top_d  = top_q;
		nxt_d  = nxt_q;
		we     = 1'b0;
		waddr  = sp_q[AddrW-1:0];
		wdata  = token.operand_value;
		beat_d.result_value    = '0;
		beat_d.expression_done = 1'b0;
		if (accept) begin
			case (token.opcode) inside
				rpn_pkg::OP_PUSH: begin
					if (full) begin
						if (held_q == rpn_pkg::ST_OK) begin
							held_d = rpn_pkg::ST_OVER;
						end
					end else begin
						sp_d  = sp_q + SpW'(1);
						top_d = token.operand_value;
						nxt_d = top_q;
						we    = 1'b1;
					end
				end
				rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
					if (!has_two) begin
						if (held_q == rpn_pkg::ST_OK) begin
							held_d = rpn_pkg::ST_UNDER;
						end
					end else begin
						// The old third entry, now second, was prefetched from the RAM last cycle.
						sp_d  = sp_q - SpW'(1);
						top_d = alu_y;
						nxt_d = ram_rd;
						we    = 1'b1;
						waddr = sp_m2[AddrW-1:0];
						wdata = alu_y;
					end
				end
				rpn_pkg::OP_END: begin
					sp_d   = '0;
					held_d = rpn_pkg::ST_OK;
					beat_d.expression_done = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (beat_d.expression_done) begin
			if (held_q != rpn_pkg::ST_OK) begin
				beat_d.status = held_q;
			end else if (sp_q != SpW'(1)) begin
				beat_d.status = rpn_pkg::ST_COUNT;
			end else begin
				beat_d.status       = rpn_pkg::ST_OK;
				beat_d.result_value = top_q;
			end
		end else begin
			beat_d.status = held_d;
		end
		beat_d.stack_depth = depth_wide[4:0];
	end

	assign depth_wide = (SpW + 5)'(sp_d);

	// Always read the entry that will sit third from the top after this cycle.
	assign rd_ptr = sp_d - SpW'(3);
	assign raddr  = rd_ptr[AddrW-1:0];

	rpn_ram #(
		.WIDTH (DW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			held_q      <= rpn_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			sp_q   <= sp_d;
			held_q <= held_d;
			if (!res_valid_q || !result_stall) begin
				res_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		nxt_q <= nxt_d;
		if (!res_valid_q || !result_stall) begin
			res_q <= beat_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SpW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && token.opcode == rpn_pkg::OP_END |=>
			result_valid && result.expression_done && result.stack_depth == 5'd0
			&& held_q == rpn_pkg::ST_OK && sp_q == '0)
		else $error("end token did not empty the stack");

	// The cached entries are not reset, so they are compared with case equality.
	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		accept && token.opcode == rpn_pkg::OP_PUSH && !full |=>
			top_q === $past(token.operand_value) && nxt_q === $past(top_q))
		else $error("push did not update the cached top entries");

	a_ok_needs_one: assert property (@(posedge clk) disable iff (!arst_n)
		accept && token.opcode == rpn_pkg::OP_END && held_q == rpn_pkg::ST_OK
			&& sp_q == SpW'(1) |=> result.status == rpn_pkg::ST_OK)
		else $error("clean single-value expression not reported ok");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Feeds postfix token streams into the calculator. The streams are directed
// corner cases, then random well-formed expressions, underflow, overflow and
// miscounted sequences. Each result beat is checked field by field against a
// predictor that keeps its own operand stack, running under varied
// sender/receiver idling and a long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STACK_SIZE = 16;
	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int PHASE_TOKENS = 450;

	// Opcodes the calculator ignores.
	localparam logic [2:0] OP_NOP_FIRST = 3'd5;
	localparam logic [2:0] OP_NOP_LAST  = 3'd7;

	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  token_valid = 1'b0;
	logic                  token_stall;
	rpn_pkg::token_beat_t  token = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	rpn_pkg::result_beat_t result;

	rpn_stack_calculator #(
		.STACK_DEPTH(STACK_SIZE)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	rpn_pkg::token_beat_t  token_q[$];
	rpn_pkg::result_beat_t expected_q[$];

	int send_idle_max = 0;
	int recv_idle_max = 0;
	bit recv_hold_req = 1'b0;
	int errors = 0;
	int tokens_accepted = 0;
	int results_seen = 0;
	int status_tally[4] = '{0, 0, 0, 0};

	// Predictor state: its own operand stack, depth and held error.
	logic [31:0] calc_stack[STACK_SIZE];
	int          calc_depth = 0;
	logic [1:0]  calc_error = rpn_pkg::ST_OK;

	function automatic rpn_pkg::result_beat_t evaluate_token(rpn_pkg::token_beat_t t);
		rpn_pkg::result_beat_t r;
		logic [31:0] lhs;
		logic [31:0] rhs;
		r = '0;
		case (t.opcode)
			rpn_pkg::OP_PUSH: begin
				if (calc_depth >= STACK_SIZE) begin
					if (calc_error == rpn_pkg::ST_OK)
						calc_error = rpn_pkg::ST_OVER;
				end else begin
					calc_stack[calc_depth] = t.operand_value;
					calc_depth++;
				end
			end
			rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
				if (calc_depth < 2) begin
					if (calc_error == rpn_pkg::ST_OK)
						calc_error = rpn_pkg::ST_UNDER;
				end else begin
					rhs = calc_stack[calc_depth-1];
					lhs = calc_stack[calc_depth-2];
					calc_depth--;
					case (t.opcode)
						rpn_pkg::OP_ADD: calc_stack[calc_depth-1] = lhs + rhs;
						rpn_pkg::OP_SUB: calc_stack[calc_depth-1] = lhs - rhs;
						default:         calc_stack[calc_depth-1] = lhs * rhs;
					endcase
				end
			end
			rpn_pkg::OP_END: begin
				r.expression_done = 1'b1;
				if (calc_error != rpn_pkg::ST_OK) begin
					r.status = calc_error;
				end else if (calc_depth != 1) begin
					r.status = rpn_pkg::ST_COUNT;
				end else begin
					r.status = rpn_pkg::ST_OK;
					r.result_value = calc_stack[0];
				end
				calc_depth = 0;
				calc_error = rpn_pkg::ST_OK;
			end
			default: ;
		endcase
		if (t.opcode != rpn_pkg::OP_END)
			r.status = calc_error;
		r.stack_depth = calc_depth[4:0];
		return r;
	endfunction

	// Driver: offers queued tokens, predicting each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin : driver
		int send_gap;
		if (!arst_n) begin
			token_valid <= 1'b0;
			token <= '0;
			send_gap = 0;
		end else begin
			if (token_valid && !token_stall) begin
				expected_q.push_back(evaluate_token(token));
				tokens_accepted++;
			end
			if (!token_valid || !token_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					token_valid <= 1'b0;
				end else if (token_q.size() > 0) begin
					token_valid <= 1'b1;
					token <= token_q.pop_front();
					send_gap = $urandom_range(0, send_idle_max);
				end else begin
					token_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks result beats and drives the stall pattern.
	always @(posedge clk or negedge arst_n) begin : monitor
		rpn_pkg::result_beat_t want;
		int recv_gap;
		int hold_left;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result.expression_done)
					status_tally[result.status]++;
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: %p", $time, result);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (result !== want) begin
						errors++;
						if (result.status !== want.status)
							$display("%0t: status expected %0d got %0d",
								$time, want.status, result.status);
						if (result.result_value !== want.result_value)
							$display("%0t: result_value expected %h got %h",
								$time, want.result_value, result.result_value);
						if (result.expression_done !== want.expression_done)
							$display("%0t: expression_done expected %b got %b",
								$time, want.expression_done, result.expression_done);
						if (result.stack_depth !== want.stack_depth)
							$display("%0t: stack_depth expected %0d got %0d",
								$time, want.stack_depth, result.stack_depth);
					end
				end
				recv_gap = $urandom_range(0, recv_idle_max);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (recv_hold_req) begin
				recv_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (token_valid && !token_stall) || (result_valid && !result_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			2: return INT_MIN;
			3: return INT_MAX;
			4: return $urandom_range(0, 20);
			5: return -$urandom_range(1, 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_arith_op();
		case ($urandom_range(0, 2))
			0: return rpn_pkg::OP_ADD;
			1: return rpn_pkg::OP_SUB;
			default: return rpn_pkg::OP_MUL;
		endcase
	endfunction

	task automatic queue_token(logic [2:0] op, logic [31:0] value);
		rpn_pkg::token_beat_t t;
		t.opcode = op;
		t.operand_value = value;
		token_q.push_back(t);
	endtask

	task automatic queue_noise_op();
		queue_token(3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST)), $urandom);
	endtask

	// A well-formed expression with 1 to 6 or STACK_SIZE operands; deep ones push everything first.
	task automatic queue_good_expr();
		int pending;
		int depth;
		bit deep;
		pending = ($urandom_range(0, 9) == 0) ? STACK_SIZE : $urandom_range(1, 6);
		deep = (pending == STACK_SIZE) && $urandom_range(0, 1);
		depth = 0;
		while (pending > 0 || depth > 1) begin
			if (depth >= 2 && (pending == 0 || (!deep && $urandom_range(0, 1)))) begin
				queue_token(pick_arith_op(), $urandom);
				depth--;
			end else begin
				queue_token(rpn_pkg::OP_PUSH, pick_operand());
				depth++;
				pending--;
			end
			if ($urandom_range(0, 19) == 0)
				queue_noise_op();
		end
		queue_token(rpn_pkg::OP_END, $urandom);
	endtask

	// Underflowing, overflowing or miscounted sequences.
	task automatic queue_bad_expr();
		int len;
		int sel;
		if ($urandom_range(0, 2) == 0) begin
			repeat (STACK_SIZE + $urandom_range(1, 3))
				queue_token(rpn_pkg::OP_PUSH, pick_operand());
			repeat ($urandom_range(0, 4))
				queue_token(pick_arith_op(), $urandom);
		end else begin
			len = $urandom_range(1, 24);
			repeat (len) begin
				sel = $urandom_range(0, 19);
				if (sel < 10)
					queue_token(rpn_pkg::OP_PUSH, pick_operand());
				else if (sel < 17)
					queue_token(pick_arith_op(), $urandom);
				else if (sel < 18)
					queue_noise_op();
				else
					queue_token(rpn_pkg::OP_END, $urandom);
			end
		end
		queue_token(rpn_pkg::OP_END, $urandom);
	endtask

	// Holds the sender back until every expected result has come in.
	task automatic wait_drained();
		while (token_q.size() != 0 || token_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random_phase(int send_max, int recv_max, bit long_hold);
		int start;
		send_idle_max = send_max;
		recv_idle_max = recv_max;
		start = token_q.size();
		while (token_q.size() - start < PHASE_TOKENS) begin
			if ($urandom_range(0, 9) < 7)
				queue_good_expr();
			else
				queue_bad_expr();
		end
		if (long_hold)
			recv_hold_req = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: wrapping arithmetic in all three operators.
		send_idle_max = 1;
		recv_idle_max = 1;
		queue_token(rpn_pkg::OP_PUSH, INT_MAX);
		queue_token(rpn_pkg::OP_PUSH, 32'd1);
		queue_token(rpn_pkg::OP_ADD, ALL_ONES);
		queue_token(rpn_pkg::OP_PUSH, INT_MAX);
		queue_token(rpn_pkg::OP_MUL, '0);
		queue_token(rpn_pkg::OP_PUSH, ALL_ONES);
		queue_token(rpn_pkg::OP_SUB, INT_MIN);
		queue_token(rpn_pkg::OP_END, INT_MAX);
		// End on an empty stack, then an operator on an empty stack.
		queue_token(rpn_pkg::OP_END, '0);
		queue_token(rpn_pkg::OP_SUB, ALL_ONES);
		queue_token(rpn_pkg::OP_END, '0);
		// Ignored opcodes between a push and its end.
		queue_token(rpn_pkg::OP_PUSH, INT_MIN);
		queue_token(OP_NOP_FIRST, ALL_ONES);
		queue_token(3'd6, INT_MAX);
		queue_token(OP_NOP_LAST, '0);
		queue_token(rpn_pkg::OP_END, ALL_ONES);
		// Too many values left at end.
		queue_token(rpn_pkg::OP_PUSH, '0);
		queue_token(rpn_pkg::OP_PUSH, ALL_ONES);
		queue_token(rpn_pkg::OP_END, '0);
		wait_drained();

		run_random_phase(4, 4, 1'b0);
		run_random_phase(0, 0, 1'b0);
		run_random_phase(0, 2, 1'b1);
		run_random_phase(4, 0, 1'b0);

		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			errors++;
		end
		$display("Covered %0d tokens and %0d results, %0d of them mismatched.",
			tokens_accepted, results_seen, errors);
		$display("Expressions ended ok %0d, underflow %0d, overflow %0d, bad count %0d.",
			status_tally[rpn_pkg::ST_OK], status_tally[rpn_pkg::ST_UNDER],
			status_tally[rpn_pkg::ST_OVER], status_tally[rpn_pkg::ST_COUNT]);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
